[rtl/core/image_sector_average_threshold_core_macros.svh]
// Assertion macros shared by the sector average core.
`ifndef IMAGE_SECTOR_AVERAGE_THRESHOLD_CORE_MACROS_SVH
`define IMAGE_SECTOR_AVERAGE_THRESHOLD_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ISAT_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);
`define ISAT_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);
`else
`define ISAT_ASSERT_IMP(lbl, ant, cons, msg)
`define ISAT_ASSERT_NXT(lbl, ant, cons, msg)
`endif
`endif

[rtl/core/isat_pkg.sv]
// Types, constants and helper functions of the sector average core.
package isat_pkg;

  localparam int IMG_SIDE_MAX = 1024;
  localparam int SEC_SIDE_MAX = 64;
  localparam int POS_W        = 10;
  localparam int SUB_W        = 6;
  localparam int SUM_W        = 20;
  localparam int DIVR_W       = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd45;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd45;
  localparam logic [6:0]  RST_SECTOR_WIDTH  = 7'd3;
  localparam logic [6:0]  RST_SECTOR_HEIGHT = 7'd3;
  localparam logic [5:0]  RST_COLS_USED     = 6'd15;
  localparam logic [7:0]  RST_THRESHOLD     = 8'd130;
  localparam logic        RST_BINARY_MODE   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_SECTOR_WIDTH  = 3'd2,
    CFG_SECTOR_HEIGHT = 3'd3,
    CFG_COLS_USED     = 3'd4,
    CFG_THRESHOLD     = 3'd5,
    CFG_BINARY_MODE   = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_DIV_W,
    ST_OUT,
    ST_RC_COL,
    ST_RC_COL_W,
    ST_RC_ROW,
    ST_RC_ROW_W
  } state_t;

  typedef struct packed {
    logic cfg_we;
    logic accept;
    logic acc;
    logic rc_col_start;
    logic rc_col_load;
    logic rc_row_start;
    logic rc_row_load;
    logic div_start;
    logic out_load;
  } isat_cmd_t;

  typedef struct packed {
    logic div_done;
    logic complete;
    logic out_free;
  } isat_sts_t;

  function automatic logic [10:0] clamp_img(input logic [10:0] v);
    logic [10:0] r;
    if (v == 11'd0) r = 11'd1;
    else if (v > 11'(IMG_SIDE_MAX)) r = 11'(IMG_SIDE_MAX);
    else r = v;
    return r;
  endfunction

  function automatic logic [6:0] clamp_sec(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'(SEC_SIDE_MAX)) r = 7'(SEC_SIDE_MAX);
    else r = v;
    return r;
  endfunction

endpackage

[rtl/core/isat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module isat_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/isat_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`include "image_sector_average_threshold_core_macros.svh"
module isat_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [isat_pkg::SUM_W-1:0]  dividend,
  input  logic [isat_pkg::DIVR_W-1:0] divisor,
  output logic                        done,
  output logic [isat_pkg::SUM_W-1:0]  quotient,
  output logic [isat_pkg::DIVR_W-1:0] remainder
);
  import isat_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] quo_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] dvs_r;
  logic [DIVR_W:0]  trial;
  logic [DIVR_W:0]  diff;
  logic             ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `ISAT_ASSERT_IMP(a_no_restart, start, !busy_r, "divider restarted while busy")
  `ISAT_ASSERT_IMP(a_rem_bound, done_r, rem_r < dvs_r, "remainder not below divisor")

endmodule

[rtl/core/isat_datapath.sv]
// Datapath: configuration, raster position, sector sums, divider and result register.
`include "image_sector_average_threshold_core_macros.svh"
module isat_datapath #(
  parameter int MAX_SECTOR_COLUMNS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  isat_pkg::isat_cmd_t            cmd,
  output isat_pkg::isat_sts_t            sts,
  input  logic [7:0]                     in_pixel,
  input  logic                           in_frame_start,
  input  logic [isat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isat_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [9:0]                     out_sector_row,
  output logic [4:0]                     out_sector_col,
  output logic [7:0]                     out_value
);
  import isat_pkg::*;

  localparam int AW = (MAX_SECTOR_COLUMNS > 1) ? $clog2(MAX_SECTOR_COLUMNS) : 1;

  logic [10:0] img_w_r, img_h_r;
  logic [6:0]  sec_w_r, sec_h_r;
  logic [5:0]  cols_r;
  logic [7:0]  thr_r;
  logic        bin_r;

  logic [POS_W-1:0] col_r, row_r, c_r, band_r;
  logic [SUB_W-1:0] scol_r, srow_r;
  logic [MAX_SECTOR_COLUMNS-1:0] vld_r;
  logic [7:0]       pix_r;
  logic [SUM_W-1:0] sum_r;
  logic [POS_W-1:0] res_row_r;
  logic [4:0]       res_col_r;
  logic             out_valid_r;

  logic [10:0] w, h;
  logic [6:0]  sw, sh;
  logic [13:0] nsec;
  logic        col_wrap, row_wrap;
  logic [POS_W-1:0] c_eff;
  logic [AW-1:0] raddr, addr;
  logic [SUM_W-1:0] rd, sum_nxt;
  logic        in_cols, col_fit, row_fit, in_range, col_last, row_last, complete;
  logic [10:0] col_end, row_end, col_inc, row_inc;
  logic        ram_we;

  logic             div_start, div_done;
  logic [SUM_W-1:0] div_dividend, quo;
  logic [DIVR_W-1:0] div_divisor, rem;
  logic [7:0]       value_nxt;

  assign w    = clamp_img(img_w_r);
  assign h    = clamp_img(img_h_r);
  assign sw   = clamp_sec(sec_w_r);
  assign sh   = clamp_sec(sec_h_r);
  assign nsec = sw * sh;

  assign col_wrap = in_frame_start || ({1'b0, col_r} >= w);
  assign row_wrap = in_frame_start || ({1'b0, row_r} >= h);
  assign c_eff    = col_wrap ? '0 : c_r;
  assign raddr    = c_eff[AW-1:0];
  assign addr     = c_r[AW-1:0];

  assign in_cols  = (c_r < {{(POS_W-6){1'b0}}, cols_r}) &&
                    ({1'b0, c_r} < 11'(MAX_SECTOR_COLUMNS));
  assign col_end  = {1'b0, col_r} - {5'b0, scol_r} + {4'b0, sw};
  assign row_end  = {1'b0, row_r} - {5'b0, srow_r} + {4'b0, sh};
  assign col_fit  = col_end <= w;
  assign row_fit  = row_end <= h;
  assign in_range = in_cols && col_fit && row_fit;
  assign col_last = {1'b0, scol_r} == (sw - 7'd1);
  assign row_last = {1'b0, srow_r} == (sh - 7'd1);
  assign complete = in_range && col_last && row_last;

  assign sum_nxt = (vld_r[addr] ? rd : '0) + SUM_W'(pix_r);
  assign ram_we  = cmd.acc && in_range && !complete;

  assign col_inc = {1'b0, col_r} + 11'd1;
  assign row_inc = {1'b0, row_r} + 11'd1;

  isat_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_SECTOR_COLUMNS)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(sum_nxt),
    .raddr(raddr),
    .rdata(rd)
  );

  assign div_start    = cmd.rc_col_start || cmd.rc_row_start || cmd.div_start;
  assign div_dividend = cmd.rc_col_start ? SUM_W'(col_r) :
                        cmd.rc_row_start ? SUM_W'(row_r) : sum_r;
  assign div_divisor  = cmd.rc_col_start ? DIVR_W'(sw) :
                        cmd.rc_row_start ? DIVR_W'(sh) : nsec[DIVR_W-1:0];

  isat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  assign value_nxt = bin_r ? {7'b0, (quo > {12'b0, thr_r})} : quo[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= RST_IMAGE_WIDTH;
      img_h_r     <= RST_IMAGE_HEIGHT;
      sec_w_r     <= RST_SECTOR_WIDTH;
      sec_h_r     <= RST_SECTOR_HEIGHT;
      cols_r      <= RST_COLS_USED;
      thr_r       <= RST_THRESHOLD;
      bin_r       <= RST_BINARY_MODE;
      col_r       <= '0;
      row_r       <= '0;
      c_r         <= '0;
      band_r      <= '0;
      scol_r      <= '0;
      srow_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IMAGE_WIDTH:   img_w_r <= cfg_data[10:0];
          CFG_IMAGE_HEIGHT:  img_h_r <= cfg_data[10:0];
          CFG_SECTOR_WIDTH:  sec_w_r <= cfg_data[6:0];
          CFG_SECTOR_HEIGHT: sec_h_r <= cfg_data[6:0];
          CFG_COLS_USED:     cols_r  <= cfg_data[5:0];
          CFG_THRESHOLD:     thr_r   <= cfg_data[7:0];
          CFG_BINARY_MODE:   bin_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (col_wrap) begin
          col_r  <= '0;
          scol_r <= '0;
          c_r    <= '0;
        end
        if (row_wrap) begin
          row_r  <= '0;
          srow_r <= '0;
          band_r <= '0;
        end
        if (in_frame_start) begin
          vld_r <= '0;
        end
      end
      if (cmd.acc) begin
        if (in_range) begin
          vld_r[addr] <= !complete;
        end
        if (col_inc >= w) begin
          col_r  <= '0;
          scol_r <= '0;
          c_r    <= '0;
          if (row_inc >= h) begin
            row_r  <= '0;
            srow_r <= '0;
            band_r <= '0;
          end else begin
            row_r <= row_inc[POS_W-1:0];
            if (row_last) begin
              srow_r <= '0;
              band_r <= band_r + POS_W'(1);
            end else begin
              srow_r <= srow_r + SUB_W'(1);
            end
          end
        end else begin
          col_r <= col_inc[POS_W-1:0];
          if (col_last) begin
            scol_r <= '0;
            c_r    <= c_r + POS_W'(1);
          end else begin
            scol_r <= scol_r + SUB_W'(1);
          end
        end
      end
      if (cmd.rc_col_load) begin
        c_r    <= quo[POS_W-1:0];
        scol_r <= rem[SUB_W-1:0];
      end
      if (cmd.rc_row_load) begin
        band_r <= quo[POS_W-1:0];
        srow_r <= rem[SUB_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= in_pixel;
    end
    if (cmd.acc && complete) begin
      sum_r     <= sum_nxt;
      res_row_r <= band_r;
      res_col_r <= c_r[4:0];
    end
    if (cmd.out_load) begin
      out_sector_row <= res_row_r;
      out_sector_col <= res_col_r;
      out_value      <= value_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.div_done = div_done;
  assign sts.complete = complete;
  assign sts.out_free = !out_valid_r || !out_stall;

  `ISAT_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_r || !out_stall,
                   "result register overwritten")
  `ISAT_ASSERT_NXT(a_complete_divides, cmd.acc && complete, cmd.div_start,
                   "completed sector not sent to divider")

endmodule

[rtl/core/isat_ctrl.sv]
// Control FSM: cfg write, re-derive, accept, accumulate, divide and result load.
`include "image_sector_average_threshold_core_macros.svh"
module isat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output isat_pkg::isat_cmd_t cmd,
  input  isat_pkg::isat_sts_t sts
);
  import isat_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cfg_ready = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          state_nxt  = ST_RC_COL;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.complete ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RC_COL: begin
        cmd.rc_col_start = 1'b1;
        state_nxt        = ST_RC_COL_W;
      end
      ST_RC_COL_W: begin
        if (sts.div_done) begin
          cmd.rc_col_load = 1'b1;
          state_nxt       = ST_RC_ROW;
        end
      end
      ST_RC_ROW: begin
        cmd.rc_row_start = 1'b1;
        state_nxt        = ST_RC_ROW_W;
      end
      ST_RC_ROW_W: begin
        if (sts.div_done) begin
          cmd.rc_row_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ISAT_ASSERT_IMP(a_cfg_excl, cmd.cfg_we, !cmd.accept,
                   "pixel accepted together with a register write")

endmodule

[rtl/core/image_sector_average_threshold_core.sv]
// Top level of the sector average / binary threshold core.
// Pixels enter in raster order; a pixel that does not finish a sector is accepted, then
// its column sum gets a read-modify-write through the registered-read sum memory. A
// pixel that finishes a sector also waits on the radix-2 divider that forms the average,
// plus any time the previous result waits on out_stall. After each configuration
// transaction the core re-derives its sector position from the raster position on the
// same divider before it takes the next pixel. Column sums are cleared by per-entry
// valid bits at reset and at frame start, so no clearing pass is needed.
module image_sector_average_threshold_core #(
  parameter int MAX_SECTOR_COLUMNS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_pixel,
  input  logic                            in_frame_start,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [isat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isat_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [9:0]                      out_sector_row,
  output logic [4:0]                      out_sector_col,
  output logic [7:0]                      out_value
);
  import isat_pkg::*;

  isat_cmd_t cmd;
  isat_sts_t sts;

  isat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  isat_datapath #(
    .MAX_SECTOR_COLUMNS(MAX_SECTOR_COLUMNS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sector_row(out_sector_row),
    .out_sector_col(out_sector_col),
    .out_value     (out_value)
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench of the sector average / threshold core: directed and random frames.
module tb_top;
  import isat_pkg::*;

  localparam int SECTOR_COLS   = 32;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PIXELS = 1650;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum int {SHADE_ANY, SHADE_FLAT, SHADE_EXTREME} shade_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [9:0] row;
    logic [4:0] col;
    logic [7:0] value;
  } sector_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_pixel       = '0;
  logic                  in_frame_start = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [9:0]            out_sector_row;
  logic [4:0]            out_sector_col;
  logic [7:0]            out_value;

  // predictor copy of the registers and the accumulation state
  logic [10:0] img_w    = RST_IMAGE_WIDTH;
  logic [10:0] img_h    = RST_IMAGE_HEIGHT;
  logic [6:0]  sec_w    = RST_SECTOR_WIDTH;
  logic [6:0]  sec_h    = RST_SECTOR_HEIGHT;
  logic [5:0]  cols_reg = RST_COLS_USED;
  logic [7:0]  thr_reg  = RST_THRESHOLD;
  logic        bin_mode = RST_BINARY_MODE;
  logic [19:0] col_sum [SECTOR_COLS] = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  pixel_t  pixel_q[$];
  sector_t sector_q[$];

  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   stall_left = 0;
  int   in_idle_pct = 20;
  int   out_stall_pct = 20;
  int   idle_cycles = 0;
  int   errors = 0;
  int   fed = 0;
  int   pixels_in = 0;
  int   sectors_expected = 0;
  int   sectors_out = 0;
  int   settings = 0;

  image_sector_average_threshold_core #(
    .MAX_SECTOR_COLUMNS(SECTOR_COLS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sector_row(out_sector_row),
    .out_sector_col(out_sector_col),
    .out_value     (out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void sector_step(input logic [7:0] pix, input logic fs);
    int unsigned w, h, sw, sh, cols, c, band, avg;
    sector_t r;
    w = fit_size(img_w, IMG_SIDE_MAX);
    h = fit_size(img_h, IMG_SIDE_MAX);
    sw = fit_size(sec_w, SEC_SIDE_MAX);
    sh = fit_size(sec_h, SEC_SIDE_MAX);
    cols = (cols_reg > SECTOR_COLS) ? SECTOR_COLS : cols_reg;
    if (fs) begin
      foreach (col_sum[i]) col_sum[i] = '0;
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos / sw;
    band = row_pos / sh;
    if (c < cols && (c + 1) * sw <= w && (band + 1) * sh <= h) begin
      col_sum[c] = col_sum[c] + pix;
      if (col_pos % sw == sw - 1 && row_pos % sh == sh - 1) begin
        avg = col_sum[c] / (sw * sh);
        r.row = band[9:0];
        r.col = c[4:0];
        r.value = bin_mode ? ((avg > thr_reg) ? 8'd1 : 8'd0) : avg[7:0];
        sector_q.push_back(r);
        sectors_expected++;
        col_sum[c] = '0;
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic int hold_len(input int pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= pct) return 0;
    if (r < pct / 8) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [7:0] shade(input shade_t style, input int base);
    int v;
    case (style)
      SHADE_ANY:  v = $urandom_range(0, 255);
      SHADE_FLAT: v = base + int'($urandom_range(0, 6)) - 3;
      default:    v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic void push_pixel(input logic [7:0] p, input logic fs);
    pixel_t item;
    item.pixel = p;
    item.frame_start = fs;
    pixel_q.push_back(item);
    fed++;
  endfunction

  function automatic void push_frame(input int npix, input logic with_fs, input shade_t style);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < npix; i++) push_pixel(shade(style, base), with_fs && i == 0);
  endfunction

  // monitor, predictor feed and watchdog
  always @(posedge clk) begin
    sector_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sector_q.size() == 0) begin
          flag($sformatf("unexpected sector row %0d col %0d value %0d",
                         out_sector_row, out_sector_col, out_value));
        end else begin
          want = sector_q.pop_front();
          sectors_out++;
          if (out_sector_row !== want.row)
            flag($sformatf("sector_row got %0d want %0d", out_sector_row, want.row));
          if (out_sector_col !== want.col)
            flag($sformatf("sector_col got %0d want %0d", out_sector_col, want.col));
          if (out_value !== want.value)
            flag($sformatf("value got %0d want %0d (row %0d col %0d)",
                           out_value, want.value, want.row, want.col));
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        sector_step(in_pixel, in_frame_start);
        pixels_in++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    pixel_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        item = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_pixel <= item.pixel;
        in_frame_start <= item.frame_start;
        in_gap = hold_len(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = hold_len(out_stall_pct);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:   img_w = data;
      CFG_IMAGE_HEIGHT:  img_h = data;
      CFG_SECTOR_WIDTH:  sec_w = data[6:0];
      CFG_SECTOR_HEIGHT: sec_h = data[6:0];
      CFG_COLS_USED:     cols_reg = data[5:0];
      CFG_THRESHOLD:     thr_reg = data[7:0];
      CFG_BINARY_MODE:   bin_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, h, sw, sh, cols, thr, bin);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cfg_write(CFG_SECTOR_WIDTH, sw);
    cfg_write(CFG_SECTOR_HEIGHT, sh);
    cfg_write(CFG_COLS_USED, cols);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_BINARY_MODE, bin);
    cfg_release();
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || sector_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h, sw, sh, cols, thr, npix, fit, frames;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: three rows of a 45-wide frame
    push_frame(45, 1'b1, SHADE_FLAT);
    push_frame(45, 1'b0, SHADE_ANY);
    push_frame(45, 1'b0, SHADE_EXTREME);
    drain();

    // 1x1 sectors, average mode: value equals the pixel
    set_frame(2, 2, 1, 1, 2, 130, 0);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd1, 1'b0);
    drain();

    // binary mode at the threshold edge, frame wrap and a mid-frame restart
    set_frame(2, 2, 1, 1, 2, 127, 1);
    push_pixel(8'd127, 1'b1);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd200, 1'b0);
    push_pixel(8'd90, 1'b1);
    drain();

    // threshold extremes
    set_frame(1, 1, 1, 1, 1, 255, 1);
    push_pixel(8'd255, 1'b1);
    drain();
    cfg_write(CFG_THRESHOLD, 0);
    cfg_release();
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd1, 1'b0);
    drain();

    // zero sizes act as 1, no columns used emits nothing, spare index ignored
    set_frame(0, 0, 0, 0, 0, 0, 1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd7, 1'b0);
    push_pixel(8'd200, 1'b1);
    drain();
    cfg_write(CFG_COLS_USED, 1);
    cfg_write(CFG_SPARE, 11'h7FF);
    cfg_release();
    push_pixel(8'd9, 1'b0);
    push_pixel(8'd0, 1'b0);
    drain();

    // partial sector column and partial bottom band
    set_frame(3, 3, 2, 2, 2, 100, 0);
    push_frame(9, 1'b1, SHADE_ANY);
    drain();

    // oversized sides and column count, upper data bits masked
    set_frame(130, 2000, 11'h7C2, 1, 11'h7FF, 11'h7FF, 11'h7FE);
    push_frame(260, 1'b1, SHADE_ANY);
    drain();

    // column count above the maximum
    set_frame(40, 1, 1, 1, 50, 100, 1);
    push_frame(40, 1'b1, SHADE_ANY);
    push_frame(40, 1'b0, SHADE_EXTREME);
    drain();

    // tallest sector
    set_frame(1, 64, 1, 64, 1, 130, 0);
    push_frame(64, 1'b1, SHADE_EXTREME);
    drain();

    while (fed < RANDOM_PIXELS) begin
      w = $urandom_range(0, 20);
      h = $urandom_range(0, 10);
      sw = $urandom_range(0, 6);
      sh = $urandom_range(0, 4);
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(16, 48);
        h = $urandom_range(0, 6);
        sw = $urandom_range(4, 16);
      end
      npix = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      fit = (w == 0 ? 1 : w) / (sw == 0 ? 1 : sw);
      case ($urandom_range(0, 9))
        0: cols = 0;
        1: cols = 63;
        default: cols = $urandom_range(1, fit + 1);
      endcase
      case ($urandom_range(0, 7))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      in_idle_pct = pick_pct();
      out_stall_pct = pick_pct();
      set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(sw), CFG_DATA_W'(sh),
                CFG_DATA_W'(cols), CFG_DATA_W'(thr), CFG_DATA_W'($urandom_range(0, 1)));
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        case ($urandom_range(0, 9))
          7: push_frame(npix, 1'b0, shade_t'($urandom_range(0, 2)));
          8: push_frame($urandom_range(1, npix), 1'b1, shade_t'($urandom_range(0, 2)));
          9: repeat ($urandom_range(1, 12))
               push_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
          default: push_frame(npix, 1'b1, shade_t'($urandom_range(0, 2)));
        endcase
      end
      drain();
    end

    if (sector_q.size() != 0) flag($sformatf("%0d sectors never arrived", sector_q.size()));
    $display("Summary: %0d pixels sent, %0d sectors checked over %0d register settings",
             pixels_in, sectors_out, settings);
    $display("Summary: %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
